FILE: design/bol_pkg.sv
// ----------------------------------------------------------------------------
// Bounded ordered list package
// Shared codes, widths and the control struct that the list cells receive.
// ----------------------------------------------------------------------------
`default_nettype none
package bol_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Action codes carried by an input item.
  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_END   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INS_KEY   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_END   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_DEL_KEY   = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_READOUT   = 3'd6;

  // Status codes carried by a result item.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // What every cell does in the current cycle.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  // How a cell decides whether it lies at or beyond the working position.
  typedef enum logic [1:0] {
    MARK_ALL     = 2'd0,
    MARK_INVALID = 2'd1,
    MARK_LAST    = 2'd2,
    MARK_KEY     = 2'd3
  } mark_sel_t;

  typedef struct packed {
    cell_op_t                  op;
    mark_sel_t                 mark_sel;
    logic signed [DATA_W-1:0]  new_value;
    logic signed [DATA_W-1:0]  match_key;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: design/bol_if.sv
// ----------------------------------------------------------------------------
// Bounded ordered list channels
// Valid/ready channel interfaces for action items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface bol_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [bol_pkg::ACTION_W-1:0]         action;
  logic signed [bol_pkg::DATA_W-1:0]    match_key;
  logic signed [bol_pkg::DATA_W-1:0]    new_value;

  modport source (output valid, action, match_key, new_value, input ready);
  modport sink   (input valid, action, match_key, new_value, output ready);
endinterface

interface bol_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [bol_pkg::STATUS_W-1:0]         status;
  logic signed [bol_pkg::DATA_W-1:0]    value_out;
  logic                                 last;
  logic [bol_pkg::COUNT_W-1:0]          entry_count;

  modport source (output valid, status, value_out, last, entry_count, input ready);
  modport sink   (input valid, status, value_out, last, entry_count, output ready);
endinterface
`default_nettype wire

FILE: design/bounded_ordered_list_top.sv
// A result item is registered at the output when its action is accepted.
// Throughput: one action per cycle unless the output stalls; a readout holds
// the input as its elements leave one by one via the single output register.
// Insert and delete shift the cells at or past the working position on accept.
// Reset (rst_n, synchronous, active low) empties the list and the output
// register; element storage is not cleared and is read only below the count.
// ----------------------------------------------------------------------------
// Bounded ordered list top level
// Chain of element cells with key search, shift insert/delete and readout.
// ----------------------------------------------------------------------------
`default_nettype none
module bounded_ordered_list_top #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  bol_in_if.sink     in_ch,
  bol_out_if.source  out_ch
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Top-level sequencer: either taking actions or streaming a readout.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                             state_r, state_nxt;
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic [IDX_W-1:0]                   rd_idx_r, rd_idx_nxt;

  // Output register.
  logic                               out_valid_r, out_valid_nxt;
  logic [bol_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [bol_pkg::DATA_W-1:0]  out_value_r, out_value_nxt;
  logic                               out_last_r, out_last_nxt;
  logic [CNT_W-1:0]                   out_count_r, out_count_nxt;

  // Cell chain wiring.
  bol_pkg::cell_ctrl_t                ctrl;
  logic signed [bol_pkg::DATA_W-1:0]  vals [LIST_DEPTH];
  logic [LIST_DEPTH:0]                valid_vec;
  logic [LIST_DEPTH:0]                mark_vec;
  logic [LIST_DEPTH-1:0]              pos_vec;
  logic signed [bol_pkg::DATA_W-1:0]  del_val;

  logic                               slot_free;
  logic                               accept;
  logic                               is_ins, is_del, full, empty, found;
  logic                               do_ins, do_del;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);

  // A cell is valid when its index lies below the element count. The entry
  // past the last cell never holds an element.
  genvar gi;
  generate
    for (gi = 0; gi <= LIST_DEPTH; gi++) begin : g_valid
      assign valid_vec[gi] = (count_r > CNT_W'(gi));
    end
  endgenerate

  assign mark_vec[0] = 1'b0;

  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      logic signed [bol_pkg::DATA_W-1:0] left_v;
      logic signed [bol_pkg::DATA_W-1:0] right_v;
      if (gi == 0) begin : g_first
        assign left_v = vals[gi];
      end else begin : g_mid_l
        assign left_v = vals[gi-1];
      end
      if (gi == LIST_DEPTH - 1) begin : g_end
        assign right_v = vals[gi];
      end else begin : g_mid_r
        assign right_v = vals[gi+1];
      end
      bol_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .valid_here (valid_vec[gi]),
        .valid_next (valid_vec[gi+1]),
        .mark_in    (mark_vec[gi]),
        .left_val   (left_v),
        .right_val  (right_v),
        .val        (vals[gi]),
        .mark_out   (mark_vec[gi+1]),
        .at_pos     (pos_vec[gi])
      );
    end
  endgenerate

  // The value removed by a delete comes from the single cell at the position.
  always_comb begin
    del_val = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (pos_vec[i]) begin
        del_val = del_val | vals[i];
      end
    end
  end

  // With a key search, the mark reaching the end of the chain tells whether
  // any valid element matched.
  assign found = mark_vec[LIST_DEPTH];

  assign is_ins = (in_ch.action == bol_pkg::ACT_INS_FRONT) ||
                  (in_ch.action == bol_pkg::ACT_INS_END) ||
                  (in_ch.action == bol_pkg::ACT_INS_KEY);
  assign is_del = (in_ch.action == bol_pkg::ACT_DEL_FRONT) ||
                  (in_ch.action == bol_pkg::ACT_DEL_END) ||
                  (in_ch.action == bol_pkg::ACT_DEL_KEY);

  assign do_ins = accept && is_ins && !full &&
                  ((in_ch.action != bol_pkg::ACT_INS_KEY) || found);
  assign do_del = accept && is_del &&
                  ((in_ch.action == bol_pkg::ACT_DEL_KEY) ? found : !empty);

  // Control broadcast to every cell.
  always_comb begin
    ctrl.new_value = in_ch.new_value;
    ctrl.match_key = in_ch.match_key;
    if (do_ins) begin
      ctrl.op = bol_pkg::CELL_INS;
    end else if (do_del) begin
      ctrl.op = bol_pkg::CELL_DEL;
    end else begin
      ctrl.op = bol_pkg::CELL_HOLD;
    end
    unique case (in_ch.action)
      bol_pkg::ACT_INS_END: ctrl.mark_sel = bol_pkg::MARK_INVALID;
      bol_pkg::ACT_DEL_END: ctrl.mark_sel = bol_pkg::MARK_LAST;
      bol_pkg::ACT_INS_KEY,
      bol_pkg::ACT_DEL_KEY: ctrl.mark_sel = bol_pkg::MARK_KEY;
      default:              ctrl.mark_sel = bol_pkg::MARK_ALL;
    endcase
  end

  // Sequencer, count and output register.
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;

    if (do_ins) begin
      count_nxt = count_r + CNT_ONE;
    end else if (do_del) begin
      count_nxt = count_r - CNT_ONE;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (is_ins || is_del || (in_ch.action == bol_pkg::ACT_READOUT))) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bol_pkg::ST_OK;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_count_nxt  = count_nxt;
          if (is_ins) begin
            if (full) begin
              out_status_nxt = bol_pkg::ST_FULL;
            end else if ((in_ch.action == bol_pkg::ACT_INS_KEY) && !found) begin
              out_status_nxt = bol_pkg::ST_NOTFOUND;
            end
          end else if (is_del) begin
            if (do_del) begin
              out_value_nxt = del_val;
            end else if (in_ch.action == bol_pkg::ACT_DEL_KEY) begin
              out_status_nxt = bol_pkg::ST_NOTFOUND;
            end else begin
              out_status_nxt = bol_pkg::ST_EMPTY;
            end
          end else begin
            // Readout: the front element goes out now, the rest follow.
            if (empty) begin
              out_status_nxt = bol_pkg::ST_EMPTY;
            end else begin
              out_value_nxt = vals[0];
              out_last_nxt  = (count_r == CNT_ONE);
              if (count_r != CNT_ONE) begin
                state_nxt  = S_READ;
                rd_idx_nxt = IDX_W'(1);
              end
            end
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bol_pkg::ST_OK;
          out_value_nxt  = vals[rd_idx_r];
          out_count_nxt  = count_r;
          out_last_nxt   = (CNT_W'(rd_idx_r) == (count_r - CNT_ONE));
          rd_idx_nxt     = rd_idx_r + IDX_W'(1);
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.value_out   = out_value_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.entry_count = bol_pkg::COUNT_W'(out_count_r);

`ifndef SYNTHESIS
  // The count never passes the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("element count beyond list depth");

  // While a readout streams, no new action is taken.
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !in_ch.ready)
    else $error("input ready during readout");

  // An empty status always reports an empty list.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == bol_pkg::ST_EMPTY)) |-> (out_count_r == '0))
    else $error("empty status with nonzero entry count");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_value_r)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

FILE: design/bol_cell.sv
// ----------------------------------------------------------------------------
// Bounded ordered list cell
// Holds one element, compares it with the key and shifts toward a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module bol_cell (
  input  wire                                 clk,
  input  bol_pkg::cell_ctrl_t                 ctrl,
  input  wire                                 valid_here,
  input  wire                                 valid_next,
  input  wire                                 mark_in,
  input  wire signed [bol_pkg::DATA_W-1:0]    left_val,
  input  wire signed [bol_pkg::DATA_W-1:0]    right_val,
  output logic signed [bol_pkg::DATA_W-1:0]   val,
  output logic                                mark_out,
  output logic                                at_pos
);

  logic signed [bol_pkg::DATA_W-1:0] val_r;
  logic signed [bol_pkg::DATA_W-1:0] val_nxt;
  logic                              mark;

  // The mark is set on every cell at or beyond the working position, so it
  // rises at most once along the chain.
  always_comb begin
    unique case (ctrl.mark_sel)
      bol_pkg::MARK_ALL:     mark = 1'b1;
      bol_pkg::MARK_INVALID: mark = !valid_here;
      bol_pkg::MARK_LAST:    mark = !valid_next;
      bol_pkg::MARK_KEY:     mark = mark_in || (valid_here && (val_r == ctrl.match_key));
      default:               mark = 1'b1;
    endcase
  end

  assign mark_out = mark;
  assign at_pos   = mark && !mark_in;
  assign val      = val_r;

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.op)
      bol_pkg::CELL_INS: begin
        if (at_pos) begin
          val_nxt = ctrl.new_value;
        end else if (mark) begin
          val_nxt = left_val;
        end
      end
      bol_pkg::CELL_DEL: begin
        if (mark) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire
